[hw/rtl/fpwc_pkg.sv]
// ----------------------------------------------------------------------------
// fpwc_pkg
// Shared widths, band thresholds, the pipeline beat type and the divide step.
// ----------------------------------------------------------------------------
package fpwc_pkg;

  localparam int CARRIER_W = 30;
  localparam int REF_W     = 25;
  localparam int SHIFT_W   = 14;
  localparam int DIV_W     = 5;
  localparam int CODE_W    = 4;
  localparam int FRAC_BITS = 19;
  localparam int PROD_W    = 19;   // out divider times shift

  // carrier long division: {carrier, 19 zero bits}, padded to a multiple of the step count
  localparam int NUM_DIV_STAGES = 13;
  localparam int A_STEPS = 4;
  localparam int QA_W    = NUM_DIV_STAGES * A_STEPS;   // 52
  localparam int RA_W    = 24;                         // pfd < 2^24
  // step word long division: {div*shift, 18 zero bits}
  localparam int B_STEPS = 3;
  localparam int QB_W    = NUM_DIV_STAGES * B_STEPS;   // 39
  localparam int RB_W    = REF_W;
  localparam int B_SCALE = 18;

  localparam int RECIP_SHIFT = 33;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int MUL_W = REF_W + 32;

  localparam logic [CARRIER_W-1:0] BAND0_MIN = 30'd705000000;
  localparam logic [CARRIER_W-1:0] BAND1_MIN = 30'd525000000;
  localparam logic [CARRIER_W-1:0] BAND2_MIN = 30'd353000000;
  localparam logic [CARRIER_W-1:0] BAND3_MIN = 30'd239000000;
  localparam logic [CARRIER_W-1:0] BAND4_MIN = 30'd177000000;

  localparam logic [CODE_W-1:0] SYNTH_SEL = 4'd8;

  localparam logic REG_REFERENCE = 1'b0;
  localparam logic REG_SHIFT     = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] band_code;
    logic [DIV_W-1:0]  out_div;
    logic [QA_W-1:0]   a_word;
    logic [RA_W-1:0]   a_rem;
    logic [RA_W-1:0]   a_den;
    logic              a_zero;
    logic [QB_W-1:0]   b_word;
    logic [RB_W-1:0]   b_rem;
    logic [RB_W-1:0]   b_den;
    logic              b_zero;
  } fpwc_div_t;

  // restoring division, a few quotient bits of each divider per stage
  function automatic fpwc_div_t div_step(fpwc_div_t d);
    fpwc_div_t r;
    logic [RA_W:0] ta;
    logic [RB_W:0] tb;
    r = d;
    for (int i = 0; i < A_STEPS; i++) begin
      ta = {r.a_rem, r.a_word[QA_W-1]};
      r.a_word = {r.a_word[QA_W-2:0], 1'b0};
      if (ta >= {1'b0, r.a_den}) begin
        ta = ta - {1'b0, r.a_den};
        r.a_word[0] = 1'b1;
      end
      r.a_rem = ta[RA_W-1:0];
    end
    for (int j = 0; j < B_STEPS; j++) begin
      tb = {r.b_rem, r.b_word[QB_W-1]};
      r.b_word = {r.b_word[QB_W-2:0], 1'b0};
      if (tb >= {1'b0, r.b_den}) begin
        tb = tb - {1'b0, r.b_den};
        r.b_word[0] = 1'b1;
      end
      r.b_rem = tb[RB_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/fpwc_front.sv]
// ----------------------------------------------------------------------------
// fpwc_front
// Band select, pfd by shift and reciprocal multiply, divider operand set-up.
// ----------------------------------------------------------------------------
module fpwc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [1:0]                     en,
  input  logic                           in_valid,
  input  logic [fpwc_pkg::CARRIER_W-1:0] carrier_hz,
  input  logic [fpwc_pkg::REF_W-1:0]     reference_hz,
  input  logic [fpwc_pkg::SHIFT_W-1:0]   shift_hz,
  output logic [1:0]                     valid,
  output fpwc_pkg::fpwc_div_t            d_out
);
  import fpwc_pkg::*;

  logic [CODE_W-1:0]    code_sel;
  logic [DIV_W-1:0]     div_sel;
  logic [REF_W-1:0]     x_sel;
  logic                 by3_sel;

  logic [CARRIER_W-1:0] f1;
  logic [CODE_W-1:0]    code1;
  logic [DIV_W-1:0]     div1;
  logic [REF_W-1:0]     x1;
  logic                 by3_1;
  logic [SHIFT_W-1:0]   shift1;
  logic [REF_W-1:0]     ref1;

  logic [CARRIER_W-1:0] f2;
  logic [CODE_W-1:0]    code2;
  logic [DIV_W-1:0]     div2;
  logic [RA_W-1:0]      xlo2;
  logic                 by3_2;
  logic [MUL_W-1:0]     prod2;
  logic [PROD_W-1:0]    p2;
  logic [REF_W-1:0]     ref2;

  logic [RA_W-1:0]      pfd;

  always_comb begin
    if (carrier_hz >= BAND0_MIN) begin
      code_sel = SYNTH_SEL + 4'd0; div_sel = 5'd4;  x_sel = reference_hz >> 1; by3_sel = 1'b0;
    end else if (carrier_hz >= BAND1_MIN) begin
      code_sel = SYNTH_SEL + 4'd1; div_sel = 5'd6;  x_sel = reference_hz;      by3_sel = 1'b1;
    end else if (carrier_hz >= BAND2_MIN) begin
      code_sel = SYNTH_SEL + 4'd2; div_sel = 5'd8;  x_sel = reference_hz >> 2; by3_sel = 1'b0;
    end else if (carrier_hz >= BAND3_MIN) begin
      code_sel = SYNTH_SEL + 4'd3; div_sel = 5'd12; x_sel = reference_hz >> 1; by3_sel = 1'b1;
    end else if (carrier_hz >= BAND4_MIN) begin
      code_sel = SYNTH_SEL + 4'd4; div_sel = 5'd16; x_sel = reference_hz >> 3; by3_sel = 1'b0;
    end else begin
      code_sel = SYNTH_SEL + 4'd5; div_sel = 5'd24; x_sel = reference_hz >> 2; by3_sel = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 2'b00;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      if (en[1]) valid[1] <= valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f1     <= carrier_hz;
      code1  <= code_sel;
      div1   <= div_sel;
      x1     <= x_sel;
      by3_1  <= by3_sel;
      shift1 <= shift_hz;
      ref1   <= reference_hz;
    end
    if (en[1]) begin
      f2    <= f1;
      code2 <= code1;
      div2  <= div1;
      xlo2  <= x1[RA_W-1:0];
      by3_2 <= by3_1;
      prod2 <= MUL_W'(x1) * MUL_W'(RECIP3);
      p2    <= PROD_W'(div1) * PROD_W'(shift1);
      ref2  <= ref1;
    end
  end

  // floor(x/3) for any 25-bit x
  assign pfd = by3_2 ? prod2[RECIP_SHIFT +: RA_W] : xlo2;

  always_comb begin
    d_out           = '0;
    d_out.band_code = code2;
    d_out.out_div   = div2;
    d_out.a_word    = QA_W'({f2, {FRAC_BITS{1'b0}}});
    d_out.a_den     = pfd;
    d_out.a_zero    = (pfd == '0);
    d_out.b_word    = QB_W'({p2, {B_SCALE{1'b0}}});
    d_out.b_den     = ref2;
    d_out.b_zero    = (ref2 == '0);
  end

endmodule

[hw/rtl/fpwc_div_stage.sv]
// ----------------------------------------------------------------------------
// fpwc_div_stage
// One registered slice of both long divisions.
// ----------------------------------------------------------------------------
module fpwc_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  fpwc_pkg::fpwc_div_t d_in,
  output logic                valid,
  output fpwc_pkg::fpwc_div_t d_out
);
  import fpwc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= div_step(d_in);
    end
  end

endmodule

[hw/rtl/fractional_pll_word_calculator_unit.sv]
// ----------------------------------------------------------------------------
// fractional_pll_word_calculator_unit
// throughput: one beat per cycle while the output is not stalled, through 2 front stages,
//   13 divider slices (4 carrier quotient bits and 3 step quotient bits each)
//   and 1 output stage
// reset: synchronous, clears all valid bits; reference 30 MHz, shift 425 Hz
// ----------------------------------------------------------------------------
module fractional_pll_word_calculator_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [fpwc_pkg::REF_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fpwc_pkg::CARRIER_W-1:0] carrier_hz,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     band_code,
  output logic [4:0]                     out_divider,
  output logic [7:0]                     int_divider,
  output logic [19:0]                    frac_divider,
  output logic [15:0]                    channel_step,
  output logic [23:0]                    deviation_word
);
  import fpwc_pkg::*;

  logic [REF_W-1:0]   reference_hz;
  logic [SHIFT_W-1:0] shift_hz;

  logic [1:0]                  en_front;
  logic [1:0]                  v_front;
  logic [NUM_DIV_STAGES-1:0]   en_div;
  logic                        en_out;
  logic                        dv [0:NUM_DIV_STAGES];
  fpwc_div_t                   d  [0:NUM_DIV_STAGES];
  fpwc_div_t                   fin;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_hz <= 25'd30000000;
      shift_hz     <= 14'd425;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REFERENCE: reference_hz <= cfg_data;
        REG_SHIFT:     shift_hz     <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage moves on when it is empty or the next one moves,
  // so bubbles close up behind a stalled output beat
  always_comb begin
    en_out = !out_valid || !out_stall;
    en_div[NUM_DIV_STAGES-1] = !dv[NUM_DIV_STAGES] || en_out;
    for (int k = NUM_DIV_STAGES - 2; k >= 0; k--) begin
      en_div[k] = !dv[k+1] || en_div[k+1];
    end
    en_front[1] = !v_front[1] || en_div[0];
    en_front[0] = !v_front[0] || en_front[1];
  end

  assign in_stall = !en_front[0];

  // band select, pfd and divider operands
  fpwc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en_front),
    .in_valid     (in_valid),
    .carrier_hz   (carrier_hz),
    .reference_hz (reference_hz),
    .shift_hz     (shift_hz),
    .valid        (v_front),
    .d_out        (d[0])
  );

  assign dv[0] = v_front[1];

  // long division slices
  for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
    fpwc_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en_div[g]),
      .valid_in (dv[g]),
      .d_in     (d[g]),
      .valid    (dv[g+1]),
      .d_out    (d[g+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= dv[NUM_DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      fin <= d[NUM_DIV_STAGES];
    end
  end

  // a zero pfd gives quotient and fraction of zero; a zero reference gives zero words
  assign band_code      = fin.band_code;
  assign out_divider    = fin.out_div;
  assign int_divider    = fin.a_zero ? 8'hFF : fin.a_word[FRAC_BITS +: 8] - 8'd1;
  assign frac_divider   = fin.a_zero ? 20'h80000 : {1'b1, fin.a_word[FRAC_BITS-1:0]};
  assign channel_step   = fin.b_zero ? 16'd0 : fin.b_word[15:0];
  assign deviation_word = fin.b_zero ? 24'd0 : fin.b_word[24:1];

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fractional PLL word calculator. Carrier
// frequencies are sent through the stall handshake while the output side
// stalls at random. Each result is checked against a predictor that
// recomputes band, dividers, fraction, channel step and deviation word in
// exact integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import fpwc_pkg::*;

  // expected output word of one carrier beat
  typedef struct packed {
    logic [3:0]  band_code;
    logic [4:0]  out_divider;
    logic [7:0]  int_divider;
    logic [19:0] frac_divider;
    logic [15:0] channel_step;
    logic [23:0] deviation_word;
  } pll_word_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;   // extra wait once every expected word is out

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = REG_REFERENCE;
  logic [REF_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CARRIER_W-1:0] carrier_hz = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           band_code;
  logic [4:0]           out_divider;
  logic [7:0]           int_divider;
  logic [19:0]          frac_divider;
  logic [15:0]          channel_step;
  logic [23:0]          deviation_word;

  // predictor copy of the configuration
  logic [REF_W-1:0]     ref_hz_model;
  logic [SHIFT_W-1:0]   shift_hz_model;

  pll_word_t            pending_words[$];
  int unsigned          mismatches = 0;
  int unsigned          idle_count = 0;
  bit                   calm = 1'b0;   // no idling on either side while set

  // band edges, reused by directed and random carriers
  logic [CARRIER_W-1:0] band_edges[5] = '{BAND0_MIN, BAND1_MIN, BAND2_MIN,
                                          BAND3_MIN, BAND4_MIN};

  fractional_pll_word_calculator_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .carrier_hz     (carrier_hz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .band_code      (band_code),
    .out_divider    (out_divider),
    .int_divider    (int_divider),
    .frac_divider   (frac_divider),
    .channel_step   (channel_step),
    .deviation_word (deviation_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // divider word computation for one carrier under the current settings
  function automatic pll_word_t calc_pll_word(logic [CARRIER_W-1:0] f);
    pll_word_t   w;
    logic [63:0] div, band, pfd, quo, rem, frac, twice_ref, prod;
    div = 4; band = 0;
    if (f < BAND0_MIN) begin div = 6;  band = 1; end
    if (f < BAND1_MIN) begin div = 8;  band = 2; end
    if (f < BAND2_MIN) begin div = 12; band = 3; end
    if (f < BAND3_MIN) begin div = 16; band = 4; end
    if (f < BAND4_MIN) begin div = 24; band = 5; end
    twice_ref = 64'(ref_hz_model) * 2;
    pfd = twice_ref / div;
    if (pfd != 0) begin
      quo  = 64'(f) / pfd;
      rem  = 64'(f) % pfd;
      frac = 64'd524288 + (rem * 64'd524288) / pfd;
    end else begin
      quo  = 0;
      frac = 64'd524288;
    end
    prod = div * 64'(shift_hz_model);
    w.band_code    = 4'(band + 64'(SYNTH_SEL));
    w.out_divider  = 5'(div);
    w.int_divider  = 8'(quo - 1);
    w.frac_divider = 20'(frac);
    if (twice_ref != 0) begin
      w.channel_step   = 16'((prod << 19) / twice_ref);
      w.deviation_word = 24'((prod << 18) / twice_ref);
    end else begin
      w.channel_step   = '0;
      w.deviation_word = '0;
    end
    return w;
  endfunction

  // wait until every expected word has come out, then let the pipe empty
  task automatic drain_pipe();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, only ever issued with the block idle
  task automatic write_reg(input logic idx, input logic [REF_W-1:0] value);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_REFERENCE) ref_hz_model = value;
    else                      shift_hz_model = value[SHIFT_W-1:0];
  endtask

  // one carrier beat, with random idle cycles in front of it
  task automatic send_carrier(input logic [CARRIER_W-1:0] f);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    carrier_hz <= f;
    do @(posedge clk); while (in_stall);
    // accepted at this edge, settings cannot change while words are pending
    pending_words.push_back(calc_pll_word(f));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CARRIER_W-1:0] rand_carrier();
    logic [CARRIER_W-1:0] f;
    case ($urandom_range(0, 9))
      0: f = CARRIER_W'(band_edges[$urandom_range(0, 4)] + $urandom_range(0, 6) - 3);
      1: f = CARRIER_W'($urandom());
      2: f = CARRIER_W'($urandom_range(0, 100000000));
      default: f = CARRIER_W'($urandom_range(119000000, 1050000000));
    endcase
    return f;
  endfunction

  // output side: random stall and the word check
  always @(posedge clk) begin
    pll_word_t want, got;
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 21);
    if (!rst && out_valid && !out_stall) begin
      got = '{band_code, out_divider, int_divider, frac_divider,
              channel_step, deviation_word};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got.band_code != want.band_code || got.out_divider != want.out_divider
            || got.int_divider != want.int_divider
            || got.frac_divider != want.frac_divider
            || got.channel_step != want.channel_step
            || got.deviation_word != want.deviation_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // reset values of both registers, with band edges and range ends
  task automatic test_reset_defaults();
    foreach (band_edges[i]) begin
      send_carrier(band_edges[i]);
      send_carrier(band_edges[i] - 30'd1);
    end
    send_carrier(30'd119000000);
    send_carrier(30'd1050000000);
    send_carrier('1);
    end_burst();
  endtask

  // carrier below pfd, zero pfd, zero reference and all-ones settings
  task automatic test_special_cases();
    send_carrier('0);
    send_carrier(30'd1000);
    send_carrier(30'd14999999);
    end_burst();
    write_reg(REG_REFERENCE, 25'd1);      // pfd is zero for every divider
    send_carrier(30'd800000000);
    send_carrier(30'd150000000);
    end_burst();
    write_reg(REG_REFERENCE, 25'd0);      // step and deviation are zero
    send_carrier(30'd433920000);
    send_carrier('1);
    end_burst();
    write_reg(REG_REFERENCE, '1);
    write_reg(REG_SHIFT, '1);             // every data bit high
    send_carrier(30'd705000000);
    send_carrier(30'd176999999);
    end_burst();
  endtask

  // random carriers under a given setting
  task automatic test_random(input logic [REF_W-1:0] ref_hz,
                             input logic [REF_W-1:0] shift, input int count);
    write_reg(REG_REFERENCE, ref_hz);
    write_reg(REG_SHIFT, shift);
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 3 && n < count / 2);   // long idle-free stretch
      if (n == count * 3 / 4) begin
        // hold off until everything in flight has come out
        end_burst();
        while (pending_words.size() != 0) @(posedge clk);
      end
      send_carrier(rand_carrier());
    end
    calm = 1'b0;
    end_burst();
  endtask

  initial begin
    ref_hz_model   = 25'd30000000;
    shift_hz_model = 14'd425;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_random(25'd30000000, 25'd425, 300);
    test_random(25'd25000000, 25'd2, 300);
    test_random(25'd32000000, 25'd9999, 300);
    test_random(25'd25000000, 25'd9999, 300);
    test_random(25'd32000000, 25'd2, 300);
    test_random(25'($urandom_range(25000000, 32000000)),
                25'($urandom_range(2, 9999)), 300);
    drain_pipe();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
